// ----- hdl/pdd_pkg.sv -----
package pdd_pkg;

    localparam int FACTOR_BITS = 24;
    localparam int SHARE_BITS  = 16;
    localparam int QUO_BITS    = 31;
    localparam int NUM_BITS    = 57;
    localparam logic [16:0] SHARE_ONE = 17'd65536;
    localparam logic [0:0]  REG_REFREEZE_ALL_MELT = 1'b0;

    // per-item data carried alongside the divider
    typedef struct packed {
        logic [30:0] pdd;
        logic [30:0] thick;
        logic [30:0] pfirn;
        logic [30:0] psnow;
        logic [30:0] fall;
        logic [23:0] ifac;
        logic [16:0] share;
        logic [31:0] snow;
        logic [30:0] firn;
        logic [30:0] ice;
        logic [31:0] snow_m;
        logic [30:0] firn_m;
        logic [23:0] sfac;
        logic        need_ice;
        logic        ovf;
    } div_pay_t;

    function automatic logic [31:0] sat_s32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -36'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [30:0] sat_u31(input logic [33:0] v);
        logic [30:0] r;
        if (|v[33:31])
            r = 31'h7FFF_FFFF;
        else
            r = v[30:0];
        return r;
    endfunction

endpackage

// ----- hdl/pdd_div.sv -----
module pdd_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [56:0]         in_rem,
    input  pdd_pkg::div_pay_t   in_pay,
    output logic                out_valid,
    output logic [30:0]         out_quo,
    output pdd_pkg::div_pay_t   out_pay
);
    import pdd_pkg::*;

    // restoring divider, one quotient bit per stage, MSB first
    logic             valid_reg [QUO_BITS];
    logic [56:0]      rem_reg   [QUO_BITS];
    logic [30:0]      quo_reg   [QUO_BITS];
    div_pay_t         pay_reg   [QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        localparam int SH = QUO_BITS - 1 - k;
        logic        valid_src;
        logic [56:0] rem_src;
        logic [30:0] quo_src;
        div_pay_t    pay_src;
        logic [56:0] trial;
        logic        take;
        logic [56:0] rem_next;
        logic [30:0] quo_next;

        if (k == 0) begin : g_first
            assign valid_src = in_valid;
            assign rem_src   = in_rem;
            assign quo_src   = '0;
            assign pay_src   = in_pay;
        end else begin : g_rest
            assign valid_src = valid_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign quo_src   = quo_reg[k-1];
            assign pay_src   = pay_reg[k-1];
        end

        always_comb
        begin
            trial    = NUM_BITS'(pay_src.sfac) << SH;
            take     = rem_src >= trial;
            rem_next = take ? rem_src - trial : rem_src;
            quo_next = quo_src | (QUO_BITS'(take) << SH);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                pay_reg[k] <= pay_src;
            end
        end
    end

    assign out_valid = valid_reg[QUO_BITS-1];
    assign out_quo   = quo_reg[QUO_BITS-1];
    assign out_pay   = pay_reg[QUO_BITS-1];

endmodule

// ----- hdl/pdd_surface_mass_balance.sv -----
// Positive-degree-day surface mass balance, one grid point per word. A
// word is taken every cycle while the result side is not stalled; the
// stages are clamp and melt-capacity multiply, melt split, a 31-stage
// restoring divider (one quotient bit per stage) that finds the degree
// days spent on snow and firn, then ice melt multiply, melt sum, refreeze
// multiply and the final clamps. One stall signal freezes the whole
// pipeline, so in_stall follows out_valid and out_stall. Register 0 at
// byte address 0, bit 0: refreeze_all_melt; change it only while idle.
module pdd_surface_mass_balance (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [30:0] degree_days,
    input  logic [30:0] column_thickness,
    input  logic [30:0] prior_firn,
    input  logic [30:0] prior_snow,
    input  logic [30:0] snowfall,
    input  logic [23:0] snow_factor,
    input  logic [23:0] ice_factor,
    input  logic [16:0] refreeze_share,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] mass_balance,
    output logic [31:0] firn_change,
    output logic [31:0] snow_change,
    output logic [30:0] total_melt,
    output logic [30:0] melt_runoff
);
    import pdd_pkg::*;

    logic en;
    logic refreeze_all_reg;

    // config port
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refreeze_all_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_REFREEZE_ALL_MELT)
        begin
            refreeze_all_reg <= pwdata[0];
        end
    end
    assign prdata = (paddr[2] == REG_REFREEZE_ALL_MELT) ? {31'b0, refreeze_all_reg} : 32'b0;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // stage 1: clamp layers, melt capacity product
    logic        s1_valid_reg;
    div_pay_t    s1_reg;
    logic [30:0] s1_cap_reg;
    logic [30:0] snow0, rem0, firn0;
    logic [54:0] cap_prod;
    div_pay_t    s1_next;

    always_comb
    begin
        snow0    = (prior_snow < column_thickness) ? prior_snow : column_thickness;
        rem0     = column_thickness - snow0;
        firn0    = (prior_firn < rem0) ? prior_firn : rem0;
        cap_prod = 55'(degree_days) * 55'(snow_factor);
        s1_next          = '0;
        s1_next.pdd      = degree_days;
        s1_next.thick    = column_thickness;
        s1_next.pfirn    = prior_firn;
        s1_next.psnow    = prior_snow;
        s1_next.fall     = snowfall;
        s1_next.ifac     = ice_factor;
        s1_next.sfac     = snow_factor;
        s1_next.share    = (refreeze_share > SHARE_ONE) ? SHARE_ONE : refreeze_share;
        s1_next.snow     = {1'b0, snow0} + {1'b0, snowfall};
        s1_next.firn     = firn0;
        s1_next.ice      = rem0 - firn0;
    end

    // stage 2: split melt between snow and firn, set up the divide
    logic        s2_valid_reg;
    div_pay_t    s2_reg;
    logic [56:0] s2_num_reg;
    div_pay_t    s2_next;
    logic [32:0] sf;
    logic [56:0] num;

    always_comb
    begin
        sf      = {1'b0, s1_reg.snow} + {2'b0, s1_reg.firn};
        num     = {sf, 24'b0};
        s2_next = s1_reg;
        s2_next.snow_m   = '0;
        s2_next.firn_m   = '0;
        s2_next.need_ice = 1'b0;
        s2_next.ovf      = num >= {2'b0, s1_reg.sfac, 31'b0};
        priority if (s1_reg.pdd == '0)
        begin
            s2_next.snow_m = '0;
        end
        else if ({1'b0, s1_cap_reg} <= s1_reg.snow)
        begin
            s2_next.snow_m = {1'b0, s1_cap_reg};
        end
        else if ({2'b0, s1_cap_reg} <= sf)
        begin
            s2_next.snow_m = s1_reg.snow;
            s2_next.firn_m = 31'({1'b0, s1_cap_reg} - s1_reg.snow);
        end
        else
        begin
            s2_next.snow_m   = s1_reg.snow;
            s2_next.firn_m   = s1_reg.firn;
            s2_next.need_ice = 1'b1;
        end
    end

    logic        dv_valid;
    logic [30:0] dv_quo;
    div_pay_t    dv_pay;

    pdd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_rem    (s2_num_reg),
        .in_pay    (s2_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_pay   (dv_pay)
    );

    // E1: degree days left for ice
    logic        e1_valid_reg;
    div_pay_t    e1_reg;
    logic [30:0] e1_excess_reg;
    logic [30:0] excess_next;

    always_comb
    begin
        if (dv_pay.need_ice && !dv_pay.ovf && dv_quo < dv_pay.pdd)
            excess_next = dv_pay.pdd - dv_quo;
        else
            excess_next = '0;
    end

    // E2: ice melt product
    logic        e2_valid_reg;
    div_pay_t    e2_reg;
    logic [54:0] e2_prod_reg;

    // E3: ice limit, melt sum, refreeze base
    logic        e3_valid_reg;
    div_pay_t    e3_reg;
    logic [33:0] e3_melt_reg;
    logic [33:0] e3_base_reg;
    logic [30:0] ice_full, ice_m;
    logic [33:0] melt_next, sfm;

    always_comb
    begin
        ice_full  = e2_prod_reg[54:24];
        ice_m     = (ice_full < e2_reg.ice) ? ice_full : e2_reg.ice;
        sfm       = {2'b0, e2_reg.snow_m} + {3'b0, e2_reg.firn_m};
        melt_next = sfm + {3'b0, ice_m};
    end

    // E4: refrozen share
    logic        e4_valid_reg;
    div_pay_t    e4_reg;
    logic [33:0] e4_melt_reg;
    logic [33:0] e4_refr_reg;
    logic [50:0] refr_prod;

    assign refr_prod = 51'(e3_base_reg) * 51'(e3_reg.share);

    // E5: runoff, balance and clamps
    logic [33:0]        runoff;
    logic signed [35:0] smb, smb_cl, fchg, schg;
    logic [30:0]        firn_new;
    logic [31:0]        snow_new;

    always_comb
    begin
        runoff   = e4_melt_reg - e4_refr_reg;
        smb      = $signed({5'b0, e4_reg.fall}) - $signed({2'b0, runoff});
        smb_cl   = ($signed({5'b0, e4_reg.thick}) + smb < 0)
                   ? -$signed({5'b0, e4_reg.thick}) : smb;
        firn_new = e4_reg.firn - e4_reg.firn_m;
        snow_new = e4_reg.snow - e4_reg.snow_m;
        fchg     = $signed({5'b0, firn_new}) - $signed({5'b0, e4_reg.pfirn});
        schg     = $signed({4'b0, snow_new}) - $signed({5'b0, e4_reg.psnow});
    end

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            e4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            e1_valid_reg  <= dv_valid;
            e2_valid_reg  <= e1_valid_reg;
            e3_valid_reg  <= e2_valid_reg;
            e4_valid_reg  <= e3_valid_reg;
            out_valid_reg <= e4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg        <= s1_next;
            s1_cap_reg    <= cap_prod[54:24];
            s2_reg        <= s2_next;
            s2_num_reg    <= num;
            e1_reg        <= dv_pay;
            e1_excess_reg <= excess_next;
            e2_reg        <= e1_reg;
            e2_prod_reg   <= 55'(e1_excess_reg) * 55'(e1_reg.ifac);
            e3_reg        <= e2_reg;
            e3_melt_reg   <= melt_next;
            e3_base_reg   <= refreeze_all_reg ? melt_next : sfm;
            e4_reg        <= e3_reg;
            e4_melt_reg   <= e3_melt_reg;
            e4_refr_reg   <= refr_prod[49:16];
            mass_balance  <= sat_s32(smb_cl);
            firn_change   <= sat_s32(fchg);
            snow_change   <= sat_s32(schg);
            total_melt    <= sat_u31(e4_melt_reg);
            melt_runoff   <= sat_u31(runoff);
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    // whole pipeline freezes exactly when the result is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow output stall");

    // refreeze never exceeds melt
    a_runoff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> melt_runoff <= total_melt)
        else $error("runoff above melt");

    // held result does not move
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mass_balance) && $stable(total_melt))
        else $error("held result changed");
`endif

endmodule
